[rtl/core/bts_pkg.sv]
// ----------------------------------------------------------------------------
// bts_pkg
// Shared types, constants and the blend function of the texture sampler.
// ----------------------------------------------------------------------------
package bts_pkg;

	localparam int MAX_SIDE    = 256;
	localparam int SIDE_BITS   = $clog2(MAX_SIDE);
	localparam int WEIGHT_BITS = 8;
	localparam int ADDR_BITS   = 16;
	localparam int TEXEL_BITS  = 32;
	localparam int COORD_BITS  = 24;
	localparam int UNIT_BITS   = 17;
	localparam int REG_BITS    = 9;

	localparam logic [UNIT_BITS-1:0] ONE_Q16 = UNIT_BITS'(32'h10000);

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		CFG_TEX_WIDTH  = 2'd0,
		CFG_TEX_HEIGHT = 2'd1,
		CFG_WRAP_MODE  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic                  wr_en;
		logic                  rd_en;
		logic [ADDR_BITS-1:0]  wr_addr;
		logic [TEXEL_BITS-1:0] wr_data;
		logic [ADDR_BITS-1:0]  addr00;
		logic [ADDR_BITS-1:0]  addr10;
		logic [ADDR_BITS-1:0]  addr01;
		logic [ADDR_BITS-1:0]  addr11;
	} mem_req_t;

	typedef logic [3:0][TEXEL_BITS-1:0] quad_t;

	function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
		input logic [WEIGHT_BITS-1:0] t);
		logic [WEIGHT_BITS:0]   tw;
		logic [WEIGHT_BITS:0]   sw;
		logic [WEIGHT_BITS+8:0] acc;
		tw  = {1'b0, t};
		sw  = (WEIGHT_BITS+1)'(1) << WEIGHT_BITS;
		acc = (WEIGHT_BITS+9)'(a) * (WEIGHT_BITS+9)'(sw - tw)
			+ (WEIGHT_BITS+9)'(b) * (WEIGHT_BITS+9)'(tw);
		return acc[WEIGHT_BITS+7:WEIGHT_BITS];
	endfunction

endpackage

[rtl/core/bts_tex_mem.sv]
// ----------------------------------------------------------------------------
// bts_tex_mem
// Texture store kept as four identical copies, one per bilinear neighbor.
// ----------------------------------------------------------------------------
module bts_tex_mem (
	input  logic              clk,
	input  bts_pkg::mem_req_t req,
	output bts_pkg::quad_t    rd_data
);
	import bts_pkg::*;

	logic [TEXEL_BITS-1:0] mem0 [2**ADDR_BITS];
	logic [TEXEL_BITS-1:0] mem1 [2**ADDR_BITS];
	logic [TEXEL_BITS-1:0] mem2 [2**ADDR_BITS];
	logic [TEXEL_BITS-1:0] mem3 [2**ADDR_BITS];
	quad_t                 rd_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem0[req.wr_addr] <= req.wr_data;
			mem1[req.wr_addr] <= req.wr_data;
			mem2[req.wr_addr] <= req.wr_data;
			mem3[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_q[0] <= mem0[req.addr00];
			rd_q[1] <= mem1[req.addr10];
			rd_q[2] <= mem2[req.addr01];
			rd_q[3] <= mem3[req.addr11];
		end
	end

	assign rd_data = rd_q;

endmodule

[rtl/core/bilinear_texture_sampler_unit.sv]
// ----------------------------------------------------------------------------
// bilinear_texture_sampler_unit
// Bilinear texture sampler with repeat or mirror coordinate wrap.
// ----------------------------------------------------------------------------
// The input stream carries one transaction per item. s_tuser selects a
// texel write or a sample. A write stores s_tdata's texel value in texture
// memory and gives no output. A sample wraps u and v, scales them by the
// texture size less one, reads the four neighbors and blends them; the
// filtered RGBA value leaves as one output transaction. The configuration
// port sets width, height and wrap mode; the user must write it only while
// idle, not enforced by the block. One item is accepted per cycle unless
// the pipeline stalls; the four neighbors come from four copies of the
// texel store, each with one read port, written together by every texel
// write. Reset empties the pipeline, sets a 1x1 size and repeat wrap; texel
// memory holds nothing defined until it is written. When the receiver stalls,
// the output holds and each stage keeps filling until the pipeline is full.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [bts_pkg::REG_BITS-1:0]  cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [95:0]                   s_tdata,  // texel_address, texel_value, coord_u, coord_v
	input  logic                          s_tuser,  // operation
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [31:0]                   m_tdata   // red, green, blue, alpha
);
	import bts_pkg::*;

	logic [REG_BITS-1:0] tex_width_q, tex_height_q;
	logic                wrap_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q  <= REG_BITS'(1);
			tex_height_q <= REG_BITS'(1);
			wrap_mode_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_TEX_WIDTH:  tex_width_q  <= cfg_data;
				CFG_TEX_HEIGHT: tex_height_q <= cfg_data;
				CFG_WRAP_MODE:  wrap_mode_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	function automatic logic [REG_BITS-1:0] eff_size(input logic [REG_BITS-1:0] s);
		if (s == '0) return REG_BITS'(1);
		if (s > REG_BITS'(MAX_SIDE)) return REG_BITS'(MAX_SIDE);
		return s;
	endfunction

	function automatic logic [UNIT_BITS-1:0] wrap_coord(input logic [COORD_BITS-1:0] raw,
		input logic mirror);
		logic [UNIT_BITS-1:0] frac;
		frac = {1'b0, raw[15:0]};
		if (!raw[COORD_BITS-1] && raw <= COORD_BITS'(ONE_Q16)) return raw[UNIT_BITS-1:0];
		if (mirror) return ONE_Q16 - frac;
		return frac;
	endfunction

	logic [REG_BITS-1:0]  w_eff, h_eff;
	logic [SIDE_BITS-1:0] wm1, hm1;

	assign w_eff = eff_size(tex_width_q);
	assign h_eff = eff_size(tex_height_q);
	assign wm1   = SIDE_BITS'(w_eff - REG_BITS'(1));
	assign hm1   = SIDE_BITS'(h_eff - REG_BITS'(1));

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

	assign rdy6     = !vld_s6 || m_tready;
	assign rdy5     = !vld_s5 || rdy6;
	assign rdy4     = !vld_s4 || rdy5;
	assign rdy3     = !vld_s3 || rdy4;
	assign rdy2     = !vld_s2 || rdy3;
	assign rdy1     = !vld_s1 || rdy2;
	assign s_tready = rdy1;

	op_t                   op_s1, op_s2, op_s3;
	logic [ADDR_BITS-1:0]  waddr_s1, waddr_s2, waddr_s3;
	logic [TEXEL_BITS-1:0] wdata_s1, wdata_s2, wdata_s3;
	logic [UNIT_BITS-1:0]  u_s1, v_s1;
	logic [SIDE_BITS-1:0]  x0_s2, y0_s2;
	logic [WEIGHT_BITS-1:0] tx_s2, ty_s2, tx_s3, ty_s3, tx_s4, ty_s4, ty_s5;
	logic [ADDR_BITS-1:0]  a00_s3, a10_s3, a01_s3, a11_s3;
	logic [3:0][7:0]       top_s5, bot_s5;
	logic [31:0]           out_s6;

	logic [UNIT_BITS+SIDE_BITS-1:0] xf, yf;
	assign xf = (UNIT_BITS+SIDE_BITS)'(u_s1) * (UNIT_BITS+SIDE_BITS)'(wm1);
	assign yf = (UNIT_BITS+SIDE_BITS)'(v_s1) * (UNIT_BITS+SIDE_BITS)'(hm1);

	logic [SIDE_BITS:0]   x0p, y0p;
	logic [SIDE_BITS-1:0] x1, y1;
	logic [ADDR_BITS:0]   row0, row1;
	assign x0p  = (SIDE_BITS+1)'(x0_s2) + (SIDE_BITS+1)'(1);
	assign y0p  = (SIDE_BITS+1)'(y0_s2) + (SIDE_BITS+1)'(1);
	assign x1   = (x0p < (SIDE_BITS+1)'(wm1)) ? x0p[SIDE_BITS-1:0] : wm1;
	assign y1   = (y0p < (SIDE_BITS+1)'(hm1)) ? y0p[SIDE_BITS-1:0] : hm1;
	assign row0 = (ADDR_BITS+1)'(y0_s2) * (ADDR_BITS+1)'(w_eff);
	assign row1 = (ADDR_BITS+1)'(y1) * (ADDR_BITS+1)'(w_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= s_tvalid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3 && (op_s3 == OP_SAMPLE);
			if (rdy5) vld_s5 <= vld_s4;
			if (rdy6) vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			op_s1    <= op_t'(s_tuser);
			waddr_s1 <= s_tdata[15:0];
			wdata_s1 <= s_tdata[47:16];
			u_s1     <= wrap_coord(s_tdata[71:48], wrap_mode_q);
			v_s1     <= wrap_coord(s_tdata[95:72], wrap_mode_q);
		end
		if (rdy2) begin
			op_s2    <= op_s1;
			waddr_s2 <= waddr_s1;
			wdata_s2 <= wdata_s1;
			x0_s2    <= xf[16+SIDE_BITS-1:16];
			y0_s2    <= yf[16+SIDE_BITS-1:16];
			tx_s2    <= xf[15:16-WEIGHT_BITS];
			ty_s2    <= yf[15:16-WEIGHT_BITS];
		end
		if (rdy3) begin
			op_s3    <= op_s2;
			waddr_s3 <= waddr_s2;
			wdata_s3 <= wdata_s2;
			a00_s3   <= ADDR_BITS'(row0 + (ADDR_BITS+1)'(x0_s2));
			a10_s3   <= ADDR_BITS'(row0 + (ADDR_BITS+1)'(x1));
			a01_s3   <= ADDR_BITS'(row1 + (ADDR_BITS+1)'(x0_s2));
			a11_s3   <= ADDR_BITS'(row1 + (ADDR_BITS+1)'(x1));
			tx_s3    <= tx_s2;
			ty_s3    <= ty_s2;
		end
		if (rdy4) begin
			tx_s4 <= tx_s3;
			ty_s4 <= ty_s3;
		end
	end

	mem_req_t req;
	quad_t    texels;

	always_comb begin
		req.wr_en   = rdy4 && vld_s3 && (op_s3 == OP_WRITE);
		req.rd_en   = rdy4 && vld_s3 && (op_s3 == OP_SAMPLE);
		req.wr_addr = waddr_s3;
		req.wr_data = wdata_s3;
		req.addr00  = a00_s3;
		req.addr10  = a10_s3;
		req.addr01  = a01_s3;
		req.addr11  = a11_s3;
	end

	bts_tex_mem u_mem (
		.clk     (clk),
		.req     (req),
		.rd_data (texels)
	);

	always_ff @(posedge clk) begin
		if (rdy5) begin
			for (int ch = 0; ch < 4; ch++) begin
				top_s5[ch] <= blend(texels[0][ch*8 +: 8], texels[1][ch*8 +: 8], tx_s4);
				bot_s5[ch] <= blend(texels[2][ch*8 +: 8], texels[3][ch*8 +: 8], tx_s4);
			end
			ty_s5 <= ty_s4;
		end
		if (rdy6) begin
			for (int ch = 0; ch < 4; ch++) begin
				out_s6[ch*8 +: 8] <= blend(top_s5[ch], bot_s5[ch], ty_s5);
			end
		end
	end

	assign m_tvalid = vld_s6;
	assign m_tdata  = out_s6;

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rdy4 && vld_s3 && op_s3 == OP_WRITE) |=> !vld_s4)
		else $error("texel write reached the filter stages");

	a_mem_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.wr_en && req.rd_en))
		else $error("texel memory read and written by one item");

	a_x_order: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (x1 >= x0_s2 && x1 <= wm1 && y1 >= y0_s2 && y1 <= hm1))
		else $error("neighbor index outside the texture");

	a_read_feeds_s4: assert property (@(posedge clk) disable iff (!arst_n)
		req.rd_en |=> vld_s4)
		else $error("texel read without a sample in the next stage");

endmodule

[tb/bilinear_texture_sampler_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bilinear_texture_sampler_unit_tb
// Self-checking testbench for the bilinear texture sampler.
// ----------------------------------------------------------------------------
// Texels are written into small textures, then samples with wrapped and
// unwrapped coordinates are sent under varying width, height and wrap mode.
// A predictor in the testbench keeps its own texture copy and computes the
// filtered color of every sample; the monitor compares each output
// transaction with the oldest predicted color. Sender gaps and receiver
// stalls vary by phase, and one long receiver hold-off fills the pipeline.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler_unit_tb;
	import bts_pkg::*;

	typedef struct packed {
		op_t         op;
		logic [15:0] addr;
		logic [31:0] value;
		logic [23:0] u;
		logic [23:0] v;
	} item_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [8:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;

	item_t       pending_items[$];
	logic [31:0] expected_colors[$];
	logic [31:0] texture[logic [15:0]];
	logic [8:0]  width_reg;
	logic [8:0]  height_reg;
	logic        mirror_reg;
	int          mismatches;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          hold_cycles = 0;
	bit          hold_request;

	bilinear_texture_sampler_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tdata(s_tdata), .s_tuser(s_tuser), .m_tvalid(m_tvalid),
		.m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned side_of(logic [8:0] r);
		if (r == 0)
			return 1;
		if (r > MAX_SIDE)
			return MAX_SIDE;
		return r;
	endfunction

	function automatic int unsigned wrapped(logic [23:0] c);
		if (!c[23] && c <= 24'h010000)
			return c;
		if (mirror_reg)
			return 32'h10000 - c[15:0];
		return c[15:0];
	endfunction

	function automatic int unsigned mix(int unsigned a, int unsigned b, int unsigned t);
		return (a * (256 - t) + b * t) >> 8;
	endfunction

	function automatic logic [31:0] filtered_color(item_t it);
		int unsigned w, h, xf, yf, x0, y0, x1, y1, tx, ty, top, bot;
		logic [31:0] c[4];
		logic [31:0] r;
		logic [15:0] a;
		w = side_of(width_reg);
		h = side_of(height_reg);
		xf = wrapped(it.u) * (w - 1);
		yf = wrapped(it.v) * (h - 1);
		x0 = xf >> 16;
		y0 = yf >> 16;
		x1 = (x0 + 1 < w - 1) ? x0 + 1 : w - 1;
		y1 = (y0 + 1 < h - 1) ? y0 + 1 : h - 1;
		tx = (xf & 16'hFFFF) >> 8;
		ty = (yf & 16'hFFFF) >> 8;
		for (int i = 0; i < 4; i++) begin
			a = 16'((i[1] ? y1 : y0) * w + (i[0] ? x1 : x0));
			c[i] = texture.exists(a) ? texture[a] : 32'h0;
		end
		for (int ch = 0; ch < 4; ch++) begin
			top = mix(c[0][ch*8 +: 8], c[1][ch*8 +: 8], tx);
			bot = mix(c[2][ch*8 +: 8], c[3][ch*8 +: 8], tx);
			r[ch*8 +: 8] = 8'(mix(top, bot, ty));
		end
		return r;
	endfunction

	// Driver: items are predicted at the edge where they are accepted.
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			if (s_tuser == OP_WRITE)
				texture[s_tdata[15:0]] = s_tdata[47:16];
			else begin
				item_t acc;
				acc.op    = OP_SAMPLE;
				acc.addr  = s_tdata[15:0];
				acc.value = s_tdata[47:16];
				acc.u     = s_tdata[71:48];
				acc.v     = s_tdata[95:72];
				expected_colors.insert(expected_colors.size(), filtered_color(acc));
			end
		end
		if (!(s_tvalid && !s_tready)) begin
			if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				item_t it;
				it = pending_items.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= it.op;
				s_tdata <= {it.v, it.u, it.value, it.addr};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (hold_request && hold_cycles < 200) begin
			m_tready <= 1'b0;
			hold_cycles <= hold_cycles + 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (expected_colors.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output transaction %h", m_tdata);
			end else begin
				logic [31:0] e;
				e = expected_colors.pop_front();
				if (e !== m_tdata) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected r%h g%h b%h a%h, got r%h g%h b%h a%h",
							e[7:0], e[15:8], e[23:16], e[31:24],
							m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[31:24]);
				end
			end
		end
	end

	task automatic drain();
		while (pending_items.size() > 0 || s_tvalid || expected_colors.size() > 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [8:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_TEX_WIDTH: width_reg = val;
			CFG_TEX_HEIGHT: height_reg = val;
			default: mirror_reg = val[0];
		endcase
	endtask

	function automatic logic [23:0] random_coord();
		case ($urandom_range(5))
			0: return 24'($urandom);
			1: return 24'h010000;
			2: return {$urandom_range(1) ? 8'hFF : 8'h00, 16'($urandom)};
			default: return 24'($urandom_range(32'h10000));
		endcase
	endfunction

	// Fills the whole texture first so that every fetch reads written texels.
	task automatic queue_texture(int unsigned w, int unsigned h);
		item_t it;
		for (int i = 0; i < w * h; i++) begin
			it = '{OP_WRITE, 16'(i), $urandom, 24'($urandom), 24'($urandom)};
			pending_items.insert(pending_items.size(), it);
		end
	endtask

	task automatic queue_samples(int n);
		item_t it;
		for (int i = 0; i < n; i++) begin
			it = '{OP_SAMPLE, 16'($urandom), $urandom, random_coord(), random_coord()};
			pending_items.insert(pending_items.size(), it);
		end
	endtask

	task automatic run_phase(logic [8:0] w, logic [8:0] h, logic m, int n);
		write_reg(CFG_TEX_WIDTH, w);
		write_reg(CFG_TEX_HEIGHT, h);
		write_reg(CFG_WRAP_MODE, {8'h0, m});
		queue_texture(side_of(w), side_of(h));
		queue_samples(n);
		drain();
	endtask

	initial begin
		item_t it;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		width_reg = 9'd1;
		height_reg = 9'd1;
		mirror_reg = 1'b0;
		mismatches = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a 4x4 texture, extreme coordinates, both wrap modes.
		write_reg(CFG_TEX_WIDTH, 9'd4);
		write_reg(CFG_TEX_HEIGHT, 9'd4);
		queue_texture(4, 4);
		it = '{OP_WRITE, 16'hFFFF, 32'hFFFFFFFF, 24'hFFFFFF, 24'hFFFFFF};
		pending_items.insert(pending_items.size(), it);
		for (int k = 0; k < 8; k++) begin
			logic [23:0] cu[8];
			cu = '{24'h000000, 24'h010000, 24'h7FFFFF, 24'h800000,
				24'hFFFFFF, 24'h010001, 24'h00FFFF, 24'hFF8000};
			it = '{OP_SAMPLE, 16'hFFFF, 32'hFFFFFFFF, cu[k], cu[7 - k]};
			pending_items.insert(pending_items.size(), it);
		end
		drain();
		write_reg(CFG_WRAP_MODE, 9'd1);
		for (int k = 0; k < 4; k++) begin
			it = '{OP_SAMPLE, 16'h0, 32'h0, k[0] ? 24'h800000 : 24'h7FFFFF,
				k[1] ? 24'hFFFFFF : 24'h010001};
			pending_items.insert(pending_items.size(), it);
		end
		drain();

		run_phase(9'd1, 9'd1, 1'b0, 100);
		run_phase(9'd0, 9'd0, 1'b1, 60);
		run_phase(9'd256, 9'd1, 1'b0, 150);
		send_idle_pct = 84;
		run_phase(9'd2, 9'd128, 1'b1, 150);
		send_idle_pct = 0;
		recv_stall_pct = 84;
		run_phase(9'd511, 9'd1, 1'b0, 150);
		send_idle_pct = 38;
		recv_stall_pct = 38;
		run_phase(9'd7, 9'd5, 1'b1, 150);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 1'b1;
		run_phase(9'd8, 9'd8, 1'b0, 150);
		run_phase(9'd3, 9'd9, 1'b1, 115);

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

[files.f]
rtl/core/bts_pkg.sv
rtl/core/bts_tex_mem.sv
rtl/core/bilinear_texture_sampler_unit.sv
tb/bilinear_texture_sampler_unit_tb.sv
